// ===== rtl/core/lmpr_pkg.sv =====
// Shared types, move codes, sensor patterns and the path shortening rules.
`default_nettype none

package lmpr_pkg;

    // Operation codes carried with each sample
    localparam logic [1:0] OP_LEARN   = 2'd0;
    localparam logic [1:0] OP_REPLAY  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_REWIND  = 2'd3;

    // Move codes, stored in the path (all but probe) and answered on the result beat
    localparam logic [2:0] MV_STOP  = 3'd0;
    localparam logic [2:0] MV_FWD   = 3'd1;
    localparam logic [2:0] MV_LEFT  = 3'd2;
    localparam logic [2:0] MV_RIGHT = 3'd3;
    localparam logic [2:0] MV_BACK  = 3'd4;
    localparam logic [2:0] MV_PROBE = 3'd5;

    // Sensor patterns, sensor 1 in the most significant bit
    localparam logic [6:0] PAT_FWD_A   = 7'b0011000;
    localparam logic [6:0] PAT_FWD_B   = 7'b0010000;
    localparam logic [6:0] PAT_LEFT_A  = 7'b1111110;
    localparam logic [6:0] PAT_LEFT_B  = 7'b1101000;
    localparam logic [6:0] PAT_LEFT_C  = 7'b1111000;
    localparam logic [6:0] PAT_RIGHT_A = 7'b0011110;
    localparam logic [6:0] PAT_RIGHT_B = 7'b0001110;
    localparam logic [6:0] PAT_FINISH  = 7'b1111111;
    localparam logic [6:0] PAT_DEAD    = 7'b0001000;
    localparam logic [6:0] PAT_BLANK   = 7'b0000000;

    // Outcome of classifying one learn sample
    typedef struct packed {
        logic       push;    // append move to the path
        logic [2:0] move;    // move to answer (and to push)
        logic       lost;    // pattern not recognized
        logic       finish;  // finish pattern seen
        logic       probe;   // dead-end probe, arm confirmation
    } class_t;

    // Outcome of one shortening rule lookup on X B Y
    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } reduce_t;

    // Left-hand rules: first entry X and last entry Y around a back move
    function automatic reduce_t shorten(input logic [2:0] first, input logic [2:0] last);
        reduce_t r;
        r.hit  = 1'b1;
        r.code = MV_STOP;
        priority if (first == MV_LEFT && last == MV_LEFT)
            r.code = MV_FWD;
        else if (first == MV_LEFT && last == MV_FWD)
            r.code = MV_RIGHT;
        else if (first == MV_RIGHT && last == MV_LEFT)
            r.code = MV_BACK;
        else if (first == MV_FWD && last == MV_FWD)
            r.code = MV_BACK;
        else if (first == MV_LEFT && last == MV_RIGHT)
            r.code = MV_BACK;
        else if (first == MV_FWD && last == MV_LEFT)
            r.code = MV_RIGHT;
        else
            r.hit = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lmpr_in_if.sv =====
// Sample channel: operation and sensor pattern with valid/ready handshake.
`default_nettype none

interface lmpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [6:0] sensors;

    modport source (output valid, output operation, output sensors, input ready);
    modport sink   (input valid, input operation, input sensors, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lmpr_out_if.sv =====
// Result channel: move, flags and path length with valid/ready handshake.
`default_nettype none

interface lmpr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] move;
    logic       lost;
    logic       end_reached;
    logic       overflow;
    logic [6:0] path_length;

    modport source (output valid, output move, output lost, output end_reached,
                    output overflow, output path_length, input ready);
    modport sink   (input valid, input move, input lost, input end_reached,
                    input overflow, input path_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/line_maze_path_recorder.sv =====
// Line-maze path recorder: learn, shorten and replay a move path.
//
// channel  | dir | beat contents
// ---------+-----+-----------------------------------------------------------
// sample   | in  | operation[1:0], sensors[6:0]
// result   | out | move[2:0], lost, end_reached, overflow, path_length[6:0]
//
// A sample passes from idle to the done state, a replay read through a read state
// between. A push then runs shortening steps, which end when fewer than three
// entries remain or no rule folds; each step reads the two entries under the top
// from the path store, and the number of steps stays below PATH_DEPTH/2.
// Reset clears path count, replay index, pending flag, output valid and the sequencer.
// A result waits in the output register; the next sample is taken meanwhile,
// and a finished result holds in the sequencer until the output register frees.
`default_nettype none

module line_maze_path_recorder #(
    parameter int PATH_DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lmpr_in_if.sink    sample,
    lmpr_out_if.source result
);

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_RED_ISSUE = 3'd1;
    localparam logic [2:0] ST_RED_EVAL  = 3'd2;
    localparam logic [2:0] ST_RPL_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rindex_reg, rindex_next;
    logic          pending_reg, pending_next;
    logic [2:0]    top_reg, top_next;

    // pending result
    logic [2:0] res_move_reg, res_move_next;
    logic       res_lost_reg, res_lost_next;
    logic       res_end_reg, res_end_next;
    logic       res_ovf_reg, res_ovf_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_move_reg, out_move_next;
    logic       out_lost_reg, out_lost_next;
    logic       out_end_reg, out_end_next;
    logic       out_ovf_reg, out_ovf_next;
    logic [6:0] out_len_reg, out_len_next;

    // memory port signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [2:0]    mem_rdata_a;
    logic [2:0]    mem_rdata_b;

    logic [CW-1:0]     cnt_m2;
    logic [CW-1:0]     cnt_m3;
    lmpr_pkg::class_t  cls;
    lmpr_pkg::reduce_t red;
    logic              accept;

    lmpr_classify u_classify (
        .sensors (sample.sensors),
        .pending (pending_reg),
        .cls     (cls)
    );

    lmpr_path_mem #(
        .DEPTH (PATH_DEPTH),
        .AW    (AW)
    ) u_path_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;

    assign cnt_m2 = count_reg - CW'(2);
    assign cnt_m3 = count_reg - CW'(3);

    // port A serves replay in idle and the middle entry while reducing
    assign mem_raddr_a = (state_reg == ST_IDLE) ? rindex_reg[AW-1:0] : cnt_m2[AW-1:0];
    assign mem_raddr_b = cnt_m3[AW-1:0];

    // rule lookup on first entry and cached top
    assign red = lmpr_pkg::shorten(mem_rdata_b, top_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rindex_next   = rindex_reg;
        pending_next  = pending_reg;
        top_next      = top_reg;
        res_move_next = res_move_reg;
        res_lost_next = res_lost_reg;
        res_end_next  = res_end_reg;
        res_ovf_next  = res_ovf_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = top_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_move_next = lmpr_pkg::MV_STOP;
                    res_lost_next = 1'b0;
                    res_end_next  = 1'b0;
                    res_ovf_next  = 1'b0;
                    pending_next  = 1'b0;
                    state_next    = ST_DONE;
                    unique case (sample.operation)
                        lmpr_pkg::OP_LEARN:
                        begin
                            res_move_next = cls.move;
                            res_lost_next = cls.lost;
                            res_end_next  = cls.finish;
                            pending_next  = cls.probe;
                            if (cls.push)
                            begin
                                if (count_reg >= DEPTH_C)
                                    res_ovf_next = 1'b1;
                                else
                                begin
                                    // push, then try to shorten
                                    mem_we     = 1'b1;
                                    mem_waddr  = count_reg[AW-1:0];
                                    mem_wdata  = cls.move;
                                    top_next   = cls.move;
                                    count_next = count_reg + CW'(1);
                                    state_next = ST_RED_ISSUE;
                                end
                            end
                        end
                        lmpr_pkg::OP_REPLAY:
                        begin
                            if (sample.sensors == lmpr_pkg::PAT_FWD_A)
                            begin
                                if (rindex_reg < count_reg)
                                begin
                                    rindex_next = rindex_reg + CW'(1);
                                    state_next  = ST_RPL_EVAL;
                                end
                                else
                                begin
                                    res_move_next = lmpr_pkg::MV_FWD;
                                    res_end_next  = 1'b1;
                                end
                            end
                            else if (sample.sensors == lmpr_pkg::PAT_BLANK)
                                res_end_next = 1'b1;
                        end
                        lmpr_pkg::OP_RESTART:
                        begin
                            count_next  = '0;
                            rindex_next = '0;
                        end
                        lmpr_pkg::OP_REWIND:
                            rindex_next = '0;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_RED_ISSUE:
            begin
                // reads of the two entries under the top go out this cycle
                if (count_reg >= CW'(3))
                    state_next = ST_RED_EVAL;
                else
                    state_next = ST_DONE;
            end
            ST_RED_EVAL:
            begin
                if (mem_rdata_a == lmpr_pkg::MV_BACK && red.hit)
                begin
                    // fold X B Y into one entry
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_m3[AW-1:0];
                    mem_wdata  = red.code;
                    top_next   = red.code;
                    count_next = cnt_m2;
                    state_next = ST_RED_ISSUE;
                end
                else
                    state_next = ST_DONE;
            end
            ST_RPL_EVAL:
            begin
                res_move_next = mem_rdata_a;
                res_end_next  = (mem_rdata_a == lmpr_pkg::MV_STOP);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output register: load from the sequencer, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_move_next  = out_move_reg;
        out_lost_next  = out_lost_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        out_len_next   = out_len_reg;
        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && (!out_valid_reg || result.ready))
        begin
            out_valid_next = 1'b1;
            out_move_next  = res_move_reg;
            out_lost_next  = res_lost_reg;
            out_end_next   = res_end_reg;
            out_ovf_next   = res_ovf_reg;
            out_len_next   = 7'(count_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rindex_reg    <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rindex_reg    <= rindex_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        res_move_reg <= res_move_next;
        res_lost_reg <= res_lost_next;
        res_end_reg  <= res_end_next;
        res_ovf_reg  <= res_ovf_next;
        out_move_reg <= out_move_next;
        out_lost_reg <= out_lost_next;
        out_end_reg  <= out_end_next;
        out_ovf_reg  <= out_ovf_next;
        out_len_reg  <= out_len_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.move        = out_move_reg;
    assign result.lost        = out_lost_reg;
    assign result.end_reached = out_end_reg;
    assign result.overflow    = out_ovf_reg;
    assign result.path_length = out_len_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lmpr_classify.sv =====
// Learn-sample classifier: maps a sensor pattern to a move, with dead-end confirm.
`default_nettype none

module lmpr_classify (
    input  wire logic           [6:0] sensors,
    input  wire logic                 pending,
    output lmpr_pkg::class_t          cls
);

    always_comb
    begin
        cls        = '0;
        cls.move   = lmpr_pkg::MV_STOP;
        // confirm a pending dead end on a blank sample
        if (pending && sensors == lmpr_pkg::PAT_BLANK)
        begin
            cls.push = 1'b1;
            cls.move = lmpr_pkg::MV_BACK;
        end
        else
        begin
            unique case (sensors)
                lmpr_pkg::PAT_FWD_A, lmpr_pkg::PAT_FWD_B:
                begin
                    cls.push = 1'b1;
                    cls.move = lmpr_pkg::MV_FWD;
                end
                lmpr_pkg::PAT_LEFT_A, lmpr_pkg::PAT_LEFT_B, lmpr_pkg::PAT_LEFT_C:
                begin
                    cls.push = 1'b1;
                    cls.move = lmpr_pkg::MV_LEFT;
                end
                lmpr_pkg::PAT_RIGHT_A, lmpr_pkg::PAT_RIGHT_B:
                begin
                    cls.push = 1'b1;
                    cls.move = lmpr_pkg::MV_RIGHT;
                end
                lmpr_pkg::PAT_FINISH:
                begin
                    cls.push   = 1'b1;
                    cls.move   = lmpr_pkg::MV_STOP;
                    cls.finish = 1'b1;
                end
                lmpr_pkg::PAT_DEAD:
                begin
                    cls.probe = 1'b1;
                    cls.move  = lmpr_pkg::MV_PROBE;
                end
                default:
                begin
                    cls.lost = 1'b1;
                    cls.move = lmpr_pkg::MV_STOP;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lmpr_path_mem.sv =====
// Path store: one write port and two registered read ports.
`default_nettype none

module lmpr_path_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [2:0]    wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [2:0]    rdata_a,
    output logic      [2:0]    rdata_b
);

    logic [2:0] mem [DEPTH];

    // write the top entry
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // register both reads
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== test/tb_line_maze_path_recorder.sv =====
// Testbench for the line-maze path recorder: random learn/replay traffic, scoreboard check.
`default_nettype none

module tb_line_maze_path_recorder;

    localparam int PATH_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 1350;

    // One expected or observed result beat
    typedef struct packed {
        logic [2:0] move;
        logic       lost;
        logic       end_reached;
        logic       overflow;
        logic [6:0] path_length;
    } outcome_t;

    // Path predictor plus the queue of results still owed by the block
    class path_scoreboard;
        logic [2:0]  trail [PATH_DEPTH];
        int unsigned trail_len;
        int unsigned replay_pos;
        bit          dead_end_armed;
        outcome_t    owed_q [$];
        int unsigned errors;
        int unsigned samples;
        int unsigned results;
        int unsigned folds;
        int unsigned drops;
        int unsigned replay_reads;

        // Collapse X B Y into one move; return 0 when no rule applies
        function bit fold_pair(input logic [2:0] x, input logic [2:0] y,
                               output logic [2:0] z);
            z = lmpr_pkg::MV_STOP;
            case ({x, y})
                {lmpr_pkg::MV_LEFT, lmpr_pkg::MV_LEFT}:  z = lmpr_pkg::MV_FWD;
                {lmpr_pkg::MV_LEFT, lmpr_pkg::MV_FWD}:   z = lmpr_pkg::MV_RIGHT;
                {lmpr_pkg::MV_RIGHT, lmpr_pkg::MV_LEFT}: z = lmpr_pkg::MV_BACK;
                {lmpr_pkg::MV_FWD, lmpr_pkg::MV_FWD}:    z = lmpr_pkg::MV_BACK;
                {lmpr_pkg::MV_LEFT, lmpr_pkg::MV_RIGHT}: z = lmpr_pkg::MV_BACK;
                {lmpr_pkg::MV_FWD, lmpr_pkg::MV_LEFT}:   z = lmpr_pkg::MV_RIGHT;
                default:                                 return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Append a move and shorten until the top no longer folds; 1 if dropped
        function bit record(input logic [2:0] code);
            logic [2:0] merged;
            if (trail_len >= PATH_DEPTH)
            begin
                drops++;
                return 1'b1;
            end
            trail[trail_len] = code;
            trail_len++;
            while (trail_len >= 3 && trail[trail_len - 2] == lmpr_pkg::MV_BACK)
            begin
                if (!fold_pair(trail[trail_len - 3], trail[trail_len - 1], merged))
                    break;
                trail_len -= 2;
                trail[trail_len - 1] = merged;
                folds++;
            end
            return 1'b0;
        endfunction

        // Predict the answer to an accepted sample beat
        function void note_sample(input logic [1:0] op, input logic [6:0] sens);
            outcome_t o;
            bit       handled;
            o       = '0;
            o.move  = lmpr_pkg::MV_STOP;
            handled = 1'b0;
            samples++;
            if (op == lmpr_pkg::OP_LEARN)
            begin
                // confirm a pending dead end on a blank sample
                if (dead_end_armed)
                begin
                    dead_end_armed = 1'b0;
                    if (sens == lmpr_pkg::PAT_BLANK)
                    begin
                        o.overflow = record(lmpr_pkg::MV_BACK);
                        o.move     = lmpr_pkg::MV_BACK;
                        handled    = 1'b1;
                    end
                end
                if (!handled)
                begin
                    case (sens)
                        lmpr_pkg::PAT_FWD_A, lmpr_pkg::PAT_FWD_B:
                        begin
                            o.overflow = record(lmpr_pkg::MV_FWD);
                            o.move     = lmpr_pkg::MV_FWD;
                        end
                        lmpr_pkg::PAT_LEFT_A, lmpr_pkg::PAT_LEFT_B, lmpr_pkg::PAT_LEFT_C:
                        begin
                            o.overflow = record(lmpr_pkg::MV_LEFT);
                            o.move     = lmpr_pkg::MV_LEFT;
                        end
                        lmpr_pkg::PAT_RIGHT_A, lmpr_pkg::PAT_RIGHT_B:
                        begin
                            o.overflow = record(lmpr_pkg::MV_RIGHT);
                            o.move     = lmpr_pkg::MV_RIGHT;
                        end
                        lmpr_pkg::PAT_FINISH:
                        begin
                            o.overflow    = record(lmpr_pkg::MV_STOP);
                            o.end_reached = 1'b1;
                        end
                        lmpr_pkg::PAT_DEAD:
                        begin
                            dead_end_armed = 1'b1;
                            o.move         = lmpr_pkg::MV_PROBE;
                        end
                        default:
                            o.lost = 1'b1;
                    endcase
                end
            end
            else
            begin
                dead_end_armed = 1'b0;
                case (op)
                    lmpr_pkg::OP_REPLAY:
                    begin
                        if (sens == lmpr_pkg::PAT_FWD_A)
                        begin
                            if (replay_pos < trail_len)
                            begin
                                o.move        = trail[replay_pos];
                                o.end_reached = (trail[replay_pos] == lmpr_pkg::MV_STOP);
                                replay_pos++;
                                replay_reads++;
                            end
                            else
                            begin
                                o.move        = lmpr_pkg::MV_FWD;
                                o.end_reached = 1'b1;
                            end
                        end
                        else if (sens == lmpr_pkg::PAT_BLANK)
                            o.end_reached = 1'b1;
                    end
                    lmpr_pkg::OP_RESTART:
                    begin
                        trail_len  = 0;
                        replay_pos = 0;
                    end
                    default:
                        replay_pos = 0;
                endcase
            end
            o.path_length = 7'(trail_len);
            owed_q.push_back(o);
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("MISMATCH at result %0d: %s", results, what);
        endtask

        // Compare a result beat field by field with the oldest prediction
        task check_result(input outcome_t got);
            outcome_t want;
            results++;
            if (owed_q.size() == 0)
            begin
                report_mismatch("result beat with no sample outstanding");
                return;
            end
            want = owed_q.pop_front();
            if (got.move !== want.move)
                report_mismatch($sformatf("move %0d, expected %0d", got.move, want.move));
            if (got.lost !== want.lost)
                report_mismatch($sformatf("lost %0b, expected %0b", got.lost, want.lost));
            if (got.end_reached !== want.end_reached)
                report_mismatch($sformatf("end_reached %0b, expected %0b",
                                          got.end_reached, want.end_reached));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %0b, expected %0b",
                                          got.overflow, want.overflow));
            if (got.path_length !== want.path_length)
                report_mismatch($sformatf("path_length %0d, expected %0d",
                                          got.path_length, want.path_length));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lmpr_in_if  sample_ch ();
    lmpr_out_if result_ch ();

    path_scoreboard sb;

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned stall_cycle;

    line_maze_path_recorder #(
        .PATH_DEPTH (PATH_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    // Clock, first rising edge one time unit in
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Note every accepted sample beat
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            sb.note_sample(sample_ch.operation, sample_ch.sensors);
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result({result_ch.move, result_ch.lost, result_ch.end_reached,
                             result_ch.overflow, result_ch.path_length});
    end

    // Result back-pressure: rotate through free, random, periodic and heavy stall phases
    initial
    begin
        result_ch.ready <= 1'b0;
        stall_cycle = 0;
        forever
        begin
            @(posedge clk);
            stall_cycle++;
            case ((stall_cycle / 400) % 4)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 9) < 7);
                2:       result_ch.ready <= ((stall_cycle % 7) < 3);
                default: result_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Drive one sample beat, idling between bursts, and hold until accepted
    task automatic send_sample(input logic [1:0] op, input logic [6:0] sens);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // leave gap-free stretches every few hundred beats
            if ((items_sent / 150) % 3 == 1 || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 7);
            if (gap > 0)
            begin
                sample_ch.valid     <= 1'b0;
                sample_ch.operation <= 2'($urandom_range(0, 3));
                sample_ch.sensors   <= 7'($urandom_range(0, 127));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid     <= 1'b1;
        sample_ch.operation <= op;
        sample_ch.sensors   <= sens;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        items_sent++;
    endtask

    // Pick one of the sensor patterns that learns the given move
    function automatic logic [6:0] learn_pattern(input logic [2:0] code);
        case (code)
            lmpr_pkg::MV_FWD:
                return $urandom_range(0, 1) ? lmpr_pkg::PAT_FWD_A : lmpr_pkg::PAT_FWD_B;
            lmpr_pkg::MV_LEFT:
            begin
                case ($urandom_range(0, 2))
                    0:       return lmpr_pkg::PAT_LEFT_A;
                    1:       return lmpr_pkg::PAT_LEFT_B;
                    default: return lmpr_pkg::PAT_LEFT_C;
                endcase
            end
            lmpr_pkg::MV_RIGHT:
                return $urandom_range(0, 1) ? lmpr_pkg::PAT_RIGHT_A : lmpr_pkg::PAT_RIGHT_B;
            default:
                return lmpr_pkg::PAT_FINISH;
        endcase
    endfunction

    // Learn a random maze walk with dead ends, so that shortening chains form
    task automatic walk_maze(input int unsigned steps);
        int unsigned k;
        int unsigned pick;
        for (k = 0; k < steps; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                send_sample(lmpr_pkg::OP_LEARN, learn_pattern(lmpr_pkg::MV_FWD));
            else if (pick < 42)
                send_sample(lmpr_pkg::OP_LEARN, learn_pattern(lmpr_pkg::MV_LEFT));
            else if (pick < 56)
                send_sample(lmpr_pkg::OP_LEARN, learn_pattern(lmpr_pkg::MV_RIGHT));
            else if (pick < 84)
            begin
                send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
                send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_BLANK);
            end
            else if (pick < 89)
            begin
                send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
                send_sample(lmpr_pkg::OP_LEARN, 7'($urandom_range(0, 127)));
            end
            else if (pick < 92)
                send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FINISH);
            else
                send_sample(lmpr_pkg::OP_LEARN, 7'($urandom_range(0, 127)));
        end
    endtask

    // Push random forward, left and right moves past the store depth, then a back and a stop
    task automatic fill_store();
        int unsigned k;
        for (k = 0; k < PATH_DEPTH + 4; k++)
            send_sample(lmpr_pkg::OP_LEARN,
                        learn_pattern(3'($urandom_range(lmpr_pkg::MV_FWD,
                                                        lmpr_pkg::MV_RIGHT))));
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_BLANK);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FINISH);
    endtask

    // Rewind and read the path back, with some blanks and stray patterns
    task automatic replay_path(input int unsigned steps);
        int unsigned k;
        int unsigned pick;
        send_sample(lmpr_pkg::OP_REWIND, 7'($urandom_range(0, 127)));
        for (k = 0; k < steps; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 84)
                send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_FWD_A);
            else if (pick < 92)
                send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_BLANK);
            else
                send_sample(lmpr_pkg::OP_REPLAY, 7'($urandom_range(0, 127)));
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned kind;
        int unsigned k;
        sb = new();
        rst_n               <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.operation <= lmpr_pkg::OP_LEARN;
        sample_ch.sensors   <= lmpr_pkg::PAT_BLANK;
        items_sent = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blank with nothing pending is not a known pattern
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_BLANK);
        // every forward, left and right pattern once
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FWD_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FWD_B);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_LEFT_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_LEFT_B);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_LEFT_C);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_RIGHT_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_RIGHT_B);
        // confirmed dead end, then two right-back-left folds
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_BLANK);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_LEFT_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_LEFT_B);
        // probe dropped by a non-blank learn sample, then by another operation
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FWD_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
        send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_FINISH);
        // finish and an unknown pattern
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_FINISH);
        send_sample(lmpr_pkg::OP_LEARN, 7'b1010101);
        // replay read, blank stop, stray pattern
        send_sample(lmpr_pkg::OP_REWIND, lmpr_pkg::PAT_BLANK);
        send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_FWD_A);
        send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_BLANK);
        send_sample(lmpr_pkg::OP_REPLAY, 7'b0101010);
        // restart, replay past an empty path, turnaround into an empty store
        send_sample(lmpr_pkg::OP_RESTART, lmpr_pkg::PAT_FINISH);
        send_sample(lmpr_pkg::OP_REPLAY, lmpr_pkg::PAT_FWD_A);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_DEAD);
        send_sample(lmpr_pkg::OP_LEARN, lmpr_pkg::PAT_BLANK);

        // random sessions: mostly learning and replay, some overflow and noise
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
                walk_maze($urandom_range(4, 40));
            else if (kind < 62)
                replay_path($urandom_range(3, 70));
            else if (kind < 67)
                fill_store();
            else if (kind < 78)
                send_sample(lmpr_pkg::OP_RESTART, 7'($urandom_range(0, 127)));
            else
            begin
                for (k = $urandom_range(1, 8); k > 0; k--)
                    send_sample(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
            end
        end
        sample_ch.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (PATH_DEPTH + 16) @(posedge clk);

        $display("Covered %0d sample beats and %0d result beats", sb.samples, sb.results);
        $display("%0d shortening steps, %0d dropped pushes, %0d replay reads",
                 sb.folds, sb.drops, sb.replay_reads);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Run limit reached with %0d results outstanding", sb.owed_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
